// ===== rtl/brd_pkg.sv =====
// ---------------------------------------------------------------------------
// Radix digit converter package
// Shared widths, character codes and the sequencer state type.
// ---------------------------------------------------------------------------
package brd_pkg;

    localparam int VALUE_PORT_W      = 64;
    localparam int RADIX_PORT_W      = 8;
    localparam int SYMBOL_W          = 7;
    localparam int DIGIT_W           = 4;
    localparam int RADIX_W           = 5;
    localparam int BITS_PER_CYCLE    = 4;
    localparam int DEF_VALUE_WIDTH   = 64;
    localparam int DEF_MAX_DIGITS    = 64;

    localparam logic [RADIX_W-1:0]  RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0]  RADIX_MAX = 5'd16;

    localparam logic [SYMBOL_W-1:0] CHAR_0 = 7'h30;
    localparam logic [SYMBOL_W-1:0] CHAR_9 = 7'h39;
    localparam logic [SYMBOL_W-1:0] CHAR_A = 7'h41;
    localparam logic [SYMBOL_W-1:0] CHAR_F = 7'h46;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_READ,
        B_SHOW
    } brd_state_t;

endpackage

// ===== rtl/brd_if.sv =====
// ---------------------------------------------------------------------------
// Radix digit converter channels
// Valid/ready channels for the number input and the digit output.
// ---------------------------------------------------------------------------
interface brd_in_if
    import brd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [VALUE_PORT_W-1:0] value;
    logic [RADIX_PORT_W-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface brd_out_if
    import brd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== rtl/binary_to_radix_digits.sv =====
// The engine loads a number in B_IDLE, divides it by the radix in B_DIV to get each digit,
// then plays each digit out through B_READ and B_SHOW, holding while dout.ready is low.
// The digit rate is set by the shared four-bit-per-cycle division step and the single
// read port of the digit store. A two-entry queue holds further numbers meanwhile.
// Reset is asynchronous and active low; it empties the queue and idles the engine.
// The digit store needs no clearing, since only digits of the current number are read.
// ---------------------------------------------------------------------------
// Binary to radix digit converter
// Converts an unsigned number into ASCII digits of a radix from 2 to 16.
// ---------------------------------------------------------------------------
module binary_to_radix_digits
    import brd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int MAX_DIGITS  = DEF_MAX_DIGITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    brd_in_if.sink    din,
    brd_out_if.source dout
);

    localparam int QW = VALUE_WIDTH + RADIX_W;

    logic          push;
    logic [QW-1:0] push_data;
    logic          full;
    logic          pop;
    logic [QW-1:0] pop_data;
    logic          empty;

    brd_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .din       (din),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    brd_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    brd_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .dout     (dout)
    );

endmodule

// ===== rtl/brd_front.sv =====
// ---------------------------------------------------------------------------
// Radix digit converter front end
// Accepts input beats, clamps the radix and trims the number for the queue.
// ---------------------------------------------------------------------------
module brd_front
    import brd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    brd_in_if.sink                        din,
    input  logic                          full,
    output logic                          push,
    output logic [VALUE_WIDTH+RADIX_W-1:0] push_data
);

    logic [RADIX_W-1:0] radix_clamped;

    always_comb
    begin
        if (din.radix < RADIX_PORT_W'(RADIX_MIN))
        begin
            radix_clamped = RADIX_MIN;
        end
        else if (din.radix > RADIX_PORT_W'(RADIX_MAX))
        begin
            radix_clamped = RADIX_MAX;
        end
        else
        begin
            radix_clamped = din.radix[RADIX_W-1:0];
        end
    end

    assign din.ready = !full;
    assign push      = din.valid && !full;
    assign push_data = {radix_clamped, din.value[VALUE_WIDTH-1:0]};

endmodule

// ===== rtl/brd_fifo.sv =====
// ---------------------------------------------------------------------------
// Radix digit converter queue
// Two-entry queue that decouples the front end from the conversion engine.
// ---------------------------------------------------------------------------
module brd_fifo #(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/brd_divider.sv =====
// ---------------------------------------------------------------------------
// Radix digit converter division step
// Four restoring division steps by the radix on a partial remainder.
// ---------------------------------------------------------------------------
module brd_divider
    import brd_pkg::*;
(
    input  logic [DIGIT_W-1:0]        rem_in,
    input  logic [BITS_PER_CYCLE-1:0] bits_in,
    input  logic [RADIX_W-1:0]        radix,
    output logic [DIGIT_W-1:0]        rem_out,
    output logic [BITS_PER_CYCLE-1:0] quot_bits
);

    always_comb
    begin
        logic [RADIX_W-1:0] r;
        logic [RADIX_W-1:0] t;
        r         = {1'b0, rem_in};
        quot_bits = '0;
        for (int i = BITS_PER_CYCLE - 1; i >= 0; i--)
        begin
            t = {r[DIGIT_W-1:0], bits_in[i]};
            if (t >= radix)
            begin
                quot_bits[i] = 1'b1;
                r            = t - radix;
            end
            else
            begin
                r = t;
            end
        end
        rem_out = r[DIGIT_W-1:0];
    end

endmodule

// ===== rtl/brd_back.sv =====
// ---------------------------------------------------------------------------
// Radix digit converter engine
// Divides repeatedly into the digit store, then plays the digits out.
// ---------------------------------------------------------------------------
module brd_back
    import brd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int MAX_DIGITS  = DEF_MAX_DIGITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           empty,
    input  logic [VALUE_WIDTH+RADIX_W-1:0] pop_data,
    output logic                           pop,
    brd_out_if.source                      dout
);

    localparam int DIV_CYCLES = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int PAD_W      = DIV_CYCLES * BITS_PER_CYCLE;
    localparam int SW         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int CW         = $clog2(MAX_DIGITS + 1);
    localparam int AW         = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    brd_state_t               state_reg;
    brd_state_t               state_next;
    logic [PAD_W-1:0]         shift_reg;
    logic [PAD_W-1:0]         shift_next;
    logic [PAD_W-1:0]         shift_step;
    logic [DIGIT_W-1:0]       rem_reg;
    logic [DIGIT_W-1:0]       rem_next;
    logic [RADIX_W-1:0]       radix_reg;
    logic [RADIX_W-1:0]       radix_next;
    logic [SW-1:0]            step_reg;
    logic [SW-1:0]            step_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [CW-1:0]            count_inc;
    logic [AW-1:0]            rd_idx_reg;
    logic [AW-1:0]            rd_idx_next;
    logic                     last_reg;
    logic [DIGIT_W-1:0]       rd_data_reg;
    logic [DIGIT_W-1:0]       digit_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0]       div_rem;
    logic [BITS_PER_CYCLE-1:0] div_quot;
    logic                     digit_done;
    logic                     room;
    logic                     wr_en;

    brd_divider u_divider (
        .rem_in    (rem_reg),
        .bits_in   (shift_reg[PAD_W-1 -: BITS_PER_CYCLE]),
        .radix     (radix_reg),
        .rem_out   (div_rem),
        .quot_bits (div_quot)
    );

    assign shift_step = {shift_reg[PAD_W-BITS_PER_CYCLE-1:0], div_quot};
    assign digit_done = (state_reg == B_DIV) && (step_reg == SW'(DIV_CYCLES - 1));
    assign room       = (count_reg < CW'(MAX_DIGITS));
    assign count_inc  = room ? (count_reg + CW'(1)) : count_reg;
    assign wr_en      = digit_done && room;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (digit_done && (shift_step == '0))
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_SHOW;
            end
            B_SHOW:
            begin
                if (dout.ready)
                begin
                    state_next = (rd_idx_reg == '0) ? B_IDLE : B_READ;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        radix_next  = radix_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                pop        = !empty;
                shift_next = PAD_W'(pop_data[VALUE_WIDTH-1:0]);
                radix_next = pop_data[VALUE_WIDTH+RADIX_W-1:VALUE_WIDTH];
                rem_next   = '0;
                step_next  = '0;
                count_next = '0;
            end
            B_DIV:
            begin
                shift_next = shift_step;
                if (digit_done)
                begin
                    rem_next    = '0;
                    step_next   = '0;
                    count_next  = count_inc;
                    rd_idx_next = AW'(count_inc - CW'(1));
                end
                else
                begin
                    rem_next  = div_rem;
                    step_next = step_reg + SW'(1);
                end
            end
            B_READ:
            begin
            end
            B_SHOW:
            begin
                if (dout.ready && (rd_idx_reg != '0))
                begin
                    rd_idx_next = rd_idx_reg - AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        dout.valid = (state_reg == B_SHOW);
        dout.last  = last_reg;
        if (rd_data_reg < DIGIT_W'(10))
        begin
            dout.symbol = CHAR_0 + SYMBOL_W'(rd_data_reg);
        end
        else
        begin
            dout.symbol = CHAR_A + SYMBOL_W'(rd_data_reg - DIGIT_W'(10));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            step_reg   <= '0;
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        if (state_reg == B_READ)
        begin
            last_reg <= (rd_idx_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            digit_mem[count_reg[AW-1:0]] <= div_rem;
        end
        if (state_reg == B_READ)
        begin
            rd_data_reg <= digit_mem[rd_idx_reg];
        end
    end

endmodule

// ===== rtl/brd_checker.sv =====
// ---------------------------------------------------------------------------
// Radix digit converter checker
// Port-level assertions on the number input and the digit stream, bound to the top level.
// ---------------------------------------------------------------------------
module brd_checker
    import brd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SYMBOL_W-1:0] out_symbol,
    input logic                out_last
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       in_beat;
    logic       last_beat;

    assign in_beat   = in_valid && in_ready;
    assign last_beat = out_valid && out_ready && out_last;

    always_comb
    begin
        pending_next = pending_reg + {2'b00, in_beat} - {2'b00, last_beat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("digit beat withdrawn before it was taken");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_symbol) && $stable(out_last))
        else $error("stalled digit beat changed");

    a_no_orphan_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("digit beat with no number outstanding");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more numbers accepted than the design can hold");

    a_legal_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_symbol >= CHAR_0 && out_symbol <= CHAR_9)
                   || (out_symbol >= CHAR_A && out_symbol <= CHAR_F))
        else $error("digit beat carries an illegal character");

endmodule

bind binary_to_radix_digits brd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (din.valid),
    .in_ready   (din.ready),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .out_symbol (dout.symbol),
    .out_last   (dout.last)
);
